### hdl/clt_pkg.sv
// Shared types, codes and character classes for the command line tokenizer.
package clt_pkg;

    // Input request and result item
    typedef struct packed {
        logic       func;
        logic [7:0] byte_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [1:0] token_type;
        logic [2:0] error_code;
        logic       last;
    } t_out_item;

    // What one byte produces: up to two results
    typedef struct packed {
        logic [1:0] n;
        t_out_item  r0;
        t_out_item  r1;
    } t_step_res;

    // Tokenizer phases
    localparam logic [2:0] PH_LINE_START  = 3'd0;
    localparam logic [2:0] PH_SKIP        = 3'd1;
    localparam logic [2:0] PH_WORD        = 3'd2;
    localparam logic [2:0] PH_UNQUOTED    = 3'd3;
    localparam logic [2:0] PH_STRING      = 3'd4;
    localparam logic [2:0] PH_ESCAPE      = 3'd5;
    localparam logic [2:0] PH_AFTER_QUOTE = 3'd6;
    localparam logic [2:0] PH_ERROR       = 3'd7;

    // Result kinds
    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_END  = 2'd1;
    localparam logic [1:0] K_ERR  = 2'd2;
    localparam logic [1:0] K_EOL  = 2'd3;

    // Token types
    localparam logic [1:0] TT_WORD     = 2'd0;
    localparam logic [1:0] TT_UNQUOTED = 2'd1;
    localparam logic [1:0] TT_QUOTED   = 2'd2;

    // Error codes
    localparam logic [2:0] E_LETTER_EXPECTED = 3'd0;
    localparam logic [2:0] E_BAD_WORD_CHAR   = 3'd1;
    localparam logic [2:0] E_BAD_UNQUOTED    = 3'd2;
    localparam logic [2:0] E_NO_CLOSE_QUOTE  = 3'd3;
    localparam logic [2:0] E_SPACE_EXPECTED  = 3'd4;

    // Function codes
    localparam logic F_WORD  = 1'b0;
    localparam logic F_PARAM = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Result queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    function automatic logic is_space(input logic [7:0] c);
        return (c >= 8'h01) && (c <= CH_SPACE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || ((c >= "0") && (c <= "9")) || (c == CH_UNDER);
    endfunction

    function automatic logic is_unquoted_char(input logic [7:0] c);
        return (c > CH_SPACE) && (c != CH_DQUOTE) && (c != CH_SQUOTE);
    endfunction

    function automatic t_out_item mk_res(input logic [1:0] kind, input logic [7:0] data,
                                         input logic [1:0] ttype, input logic [2:0] err);
        t_out_item r;
        r.kind       = kind;
        r.data       = data;
        r.token_type = ttype;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

### hdl/clt_core.sv
// Tokenizer state and per-byte transition logic.
module clt_core
    import clt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_step_res o_res
);

    logic [2:0] r_phase, n_phase;
    logic [1:0] r_cur_type, n_cur_type;
    t_step_res  w_res;
    logic [7:0] c;

    assign c = i_item.byte_req;

    always_comb begin
        n_phase    = r_phase;
        n_cur_type = r_cur_type;
        w_res.n    = 2'd0;
        w_res.r0   = '0;
        w_res.r1   = '0;
        case (r_phase)
            PH_LINE_START, PH_SKIP: begin
                if (c == CH_NUL) begin
                    w_res.n  = 2'd1;
                    w_res.r0 = mk_res(K_EOL, CH_NUL, TT_WORD, E_LETTER_EXPECTED);
                    n_phase  = PH_LINE_START;
                end else if ((r_phase == PH_SKIP) && is_space(c)) begin
                    // whitespace between tokens, nothing out
                end else if (i_item.func == F_WORD) begin
                    w_res.n = 2'd1;
                    if (is_letter(c)) begin
                        n_cur_type = TT_WORD;
                        w_res.r0   = mk_res(K_DATA, c, TT_WORD, E_LETTER_EXPECTED);
                        n_phase    = PH_WORD;
                    end else begin
                        w_res.r0 = mk_res(K_ERR, CH_NUL, TT_WORD, E_LETTER_EXPECTED);
                        n_phase  = PH_ERROR;
                    end
                end else if (c == CH_DQUOTE) begin
                    n_cur_type = TT_QUOTED;
                    n_phase    = PH_STRING;
                end else if (is_unquoted_char(c)) begin
                    n_cur_type = TT_UNQUOTED;
                    w_res.n    = 2'd1;
                    w_res.r0   = mk_res(K_DATA, c, TT_UNQUOTED, E_LETTER_EXPECTED);
                    n_phase    = PH_UNQUOTED;
                end else begin
                    w_res.n  = 2'd1;
                    w_res.r0 = mk_res(K_ERR, CH_NUL, TT_WORD, E_BAD_UNQUOTED);
                    n_phase  = PH_ERROR;
                end
            end
            PH_WORD, PH_UNQUOTED, PH_AFTER_QUOTE: begin
                w_res.n = 2'd1;
                if (c == CH_NUL) begin
                    w_res.n  = 2'd2;
                    w_res.r0 = mk_res(K_END, CH_NUL, r_cur_type, E_LETTER_EXPECTED);
                    w_res.r1 = mk_res(K_EOL, CH_NUL, TT_WORD, E_LETTER_EXPECTED);
                    n_phase  = PH_LINE_START;
                end else if (is_space(c)) begin
                    w_res.r0 = mk_res(K_END, CH_NUL, r_cur_type, E_LETTER_EXPECTED);
                    n_phase  = PH_SKIP;
                end else if ((r_phase == PH_WORD) && is_word_char(c)) begin
                    w_res.r0 = mk_res(K_DATA, c, r_cur_type, E_LETTER_EXPECTED);
                end else if ((r_phase == PH_UNQUOTED) && is_unquoted_char(c)) begin
                    w_res.r0 = mk_res(K_DATA, c, r_cur_type, E_LETTER_EXPECTED);
                end else begin
                    w_res.r0 = mk_res(K_ERR, CH_NUL, TT_WORD,
                                      (r_phase == PH_WORD)     ? E_BAD_WORD_CHAR :
                                      (r_phase == PH_UNQUOTED) ? E_BAD_UNQUOTED  :
                                                                 E_SPACE_EXPECTED);
                    n_phase  = PH_ERROR;
                end
            end
            PH_STRING, PH_ESCAPE: begin
                if (c == CH_NUL) begin
                    w_res.n  = 2'd2;
                    w_res.r0 = mk_res(K_ERR, CH_NUL, TT_WORD, E_NO_CLOSE_QUOTE);
                    w_res.r1 = mk_res(K_EOL, CH_NUL, TT_WORD, E_LETTER_EXPECTED);
                    n_phase  = PH_LINE_START;
                end else if ((r_phase == PH_STRING) && (c == CH_DQUOTE)) begin
                    n_phase = PH_AFTER_QUOTE;
                end else if ((r_phase == PH_STRING) && (c == CH_BSLASH)) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    w_res.n  = 2'd1;
                    w_res.r0 = mk_res(K_DATA, c, r_cur_type, E_LETTER_EXPECTED);
                    n_phase  = PH_STRING;
                end
            end
            default: begin
                // sticky error until end of line
                if (c == CH_NUL) begin
                    w_res.n  = 2'd1;
                    w_res.r0 = mk_res(K_EOL, CH_NUL, TT_WORD, E_LETTER_EXPECTED);
                    n_phase  = PH_LINE_START;
                end
            end
        endcase
        if (w_res.n == 2'd1) w_res.r0.last = 1'b1;
        if (w_res.n == 2'd2) w_res.r1.last = 1'b1;
    end

    assign o_res = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LINE_START;
            r_cur_type <= TT_WORD;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_cur_type <= n_cur_type;
        end
    end

endmodule

### hdl/command_line_tokenizer.sv
// Command line tokenizer top level: input register, tokenizer core, result queue.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one command line
// byte per request together with the func bit; byte 0 ends the line.
// Output channel (o_out_valid / i_out_ready / o_out_item) gives token bytes,
// token ends, errors and end-of-line markers; last marks the final result of
// a byte. Bytes that cause no result (skipped whitespace, quotes, escapes,
// bytes after an error) vanish silently.
// A byte waits in the input register until two queue entries are free, room
// for its results, which are written into the queue and offered from there.
// Throughput: one byte per cycle while the queue has room; the two results
// of a byte (end of line inside a token or string) leave one at a time
// through the single output port of the four-entry result queue.
// Reset clears the queue, the input register and the tokenizer state to line
// start. When the receiver stalls, results collect in the queue; once fewer
// than two entries are free the held byte waits and o_in_ready drops.
module command_line_tokenizer
    import clt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic             r_in_valid;
    t_in_item         r_in_item;
    t_out_item        r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_head, r_tail;
    logic [Q_CW-1:0]  r_count, n_count;
    logic [Q_CW-1:0]  w_used;
    logic             w_pop, w_process;
    logic [1:0]       w_push;
    t_step_res        w_res;

    assign w_pop       = o_out_valid && i_out_ready;
    assign w_used      = r_count - Q_CW'(w_pop);
    assign w_process   = r_in_valid && (w_used <= Q_CW'(Q_DEPTH - 2));
    assign w_push      = w_process ? w_res.n : 2'd0;
    assign n_count     = w_used + Q_CW'(w_push);
    assign o_in_ready  = !r_in_valid || w_process;
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_q[r_head];

    clt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_process),
        .i_item  (r_in_item),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (w_pop) r_head <= r_head + Q_AW'(1);
            r_tail  <= r_tail + Q_AW'(w_push);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in_item <= i_in_item;
        if (w_push != 2'd0) r_q[r_tail] <= w_res.r0;
        if (w_push == 2'd2) r_q[r_tail + Q_AW'(1)] <= w_res.r1;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("result queue overfilled");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process || w_pop |=> r_count == $past(n_count))
        else $error("queue count out of step");

    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process && (w_res.n == 2'd2) |-> w_res.r1.last && !w_res.r0.last
        && (w_res.r1.kind == K_EOL))
        else $error("two-result byte not framed as result then end of line");

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == K_EOL) |-> o_out_item.last)
        else $error("end of line not marked last");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_process |=> r_in_valid && $stable(r_in_item))
        else $error("held request lost");

endmodule

### verif/clt_checker.sv
// Tokenizer checker: predicts results from accepted requests and compares them in order.
module clt_checker
    import clt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;

    logic [2:0] tok_phase;
    logic [1:0] tok_type;
    t_out_item  expected_results[$];
    t_out_item  step_results[$];
    t_out_item  oldest;

    function automatic logic blank_char(input logic [7:0] c);
        return (c >= 8'h01) && (c <= CH_SPACE);
    endfunction

    function automatic logic alpha_char(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic ident_char(input logic [7:0] c);
        return alpha_char(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
    endfunction

    function automatic logic bare_char(input logic [7:0] c);
        return (c > CH_SPACE) && (c != CH_DQUOTE) && (c != CH_SQUOTE);
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                        input logic [1:0] ttype, input logic [2:0] err);
        t_out_item r;
        r.kind       = kind;
        r.data       = data;
        r.token_type = ttype;
        r.error_code = err;
        r.last       = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic tokenize_byte(input t_in_item req);
        logic [7:0] c;
        c = req.byte_req;
        step_results.delete();
        case (tok_phase)
            PH_LINE_START, PH_SKIP: begin
                if (c == CH_NUL) begin
                    emit(K_EOL, 8'h00, TT_WORD, 3'd0);
                    tok_phase = PH_LINE_START;
                end else if (tok_phase == PH_SKIP && blank_char(c)) begin
                    // gap between tokens, nothing out
                end else if (req.func == F_WORD) begin
                    if (alpha_char(c)) begin
                        tok_type = TT_WORD;
                        emit(K_DATA, c, TT_WORD, 3'd0);
                        tok_phase = PH_WORD;
                    end else begin
                        emit(K_ERR, 8'h00, TT_WORD, E_LETTER_EXPECTED);
                        tok_phase = PH_ERROR;
                    end
                end else if (c == CH_DQUOTE) begin
                    tok_type = TT_QUOTED;
                    tok_phase = PH_STRING;
                end else if (bare_char(c)) begin
                    tok_type = TT_UNQUOTED;
                    emit(K_DATA, c, TT_UNQUOTED, 3'd0);
                    tok_phase = PH_UNQUOTED;
                end else begin
                    emit(K_ERR, 8'h00, TT_WORD, E_BAD_UNQUOTED);
                    tok_phase = PH_ERROR;
                end
            end
            PH_WORD, PH_UNQUOTED, PH_AFTER_QUOTE: begin
                if (c == CH_NUL) begin
                    emit(K_END, 8'h00, tok_type, 3'd0);
                    emit(K_EOL, 8'h00, TT_WORD, 3'd0);
                    tok_phase = PH_LINE_START;
                end else if (blank_char(c)) begin
                    emit(K_END, 8'h00, tok_type, 3'd0);
                    tok_phase = PH_SKIP;
                end else if (tok_phase == PH_WORD && ident_char(c)) begin
                    emit(K_DATA, c, tok_type, 3'd0);
                end else if (tok_phase == PH_UNQUOTED && bare_char(c)) begin
                    emit(K_DATA, c, tok_type, 3'd0);
                end else begin
                    if (tok_phase == PH_WORD)
                        emit(K_ERR, 8'h00, TT_WORD, E_BAD_WORD_CHAR);
                    else if (tok_phase == PH_UNQUOTED)
                        emit(K_ERR, 8'h00, TT_WORD, E_BAD_UNQUOTED);
                    else
                        emit(K_ERR, 8'h00, TT_WORD, E_SPACE_EXPECTED);
                    tok_phase = PH_ERROR;
                end
            end
            PH_STRING, PH_ESCAPE: begin
                if (c == CH_NUL) begin
                    emit(K_ERR, 8'h00, TT_WORD, E_NO_CLOSE_QUOTE);
                    emit(K_EOL, 8'h00, TT_WORD, 3'd0);
                    tok_phase = PH_LINE_START;
                end else if (tok_phase == PH_STRING && c == CH_DQUOTE) begin
                    tok_phase = PH_AFTER_QUOTE;
                end else if (tok_phase == PH_STRING && c == CH_BSLASH) begin
                    tok_phase = PH_ESCAPE;
                end else begin
                    // plain or escaped byte goes through as it is
                    emit(K_DATA, c, tok_type, 3'd0);
                    tok_phase = PH_STRING;
                end
            end
            default: begin
                // sticky error: only end of line gets out
                if (c == CH_NUL) begin
                    emit(K_EOL, 8'h00, TT_WORD, 3'd0);
                    tok_phase = PH_LINE_START;
                end
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        while (step_results.size() > 0)
            expected_results.push_back(step_results.pop_front());
    endtask

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_MAX)
            $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_phase = PH_LINE_START;
            tok_type  = TT_WORD;
            expected_results.delete();
        end else begin
            // results pass the input register and queue after their request, so check first
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf(
                        "%0t: unexpected result kind=%0d data=%02h type=%0d err=%0d last=%0b",
                        $time, i_out_item.kind, i_out_item.data, i_out_item.token_type,
                        i_out_item.error_code, i_out_item.last));
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_out_item.kind !== oldest.kind || i_out_item.data !== oldest.data ||
                        i_out_item.token_type !== oldest.token_type ||
                        i_out_item.error_code !== oldest.error_code ||
                        i_out_item.last !== oldest.last) begin
                        note_failure($sformatf({"%0t: mismatch expected kind=%0d data=%02h ",
                            "type=%0d err=%0d last=%0b, got kind=%0d data=%02h type=%0d ",
                            "err=%0d last=%0b"}, $time,
                            oldest.kind, oldest.data, oldest.token_type,
                            oldest.error_code, oldest.last,
                            i_out_item.kind, i_out_item.data, i_out_item.token_type,
                            i_out_item.error_code, i_out_item.last));
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_in_item);
        end
        o_pending = expected_results.size();
    end

endmodule

### verif/tb.sv
// Tokenizer testbench top: clock, reset, command line stimulus and the final verdict.
module tb;
    import clt_pkg::*;

    localparam int ITEMS       = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 20;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int          fail_count;
    int          pending;
    int          sent = 0;
    bit          no_idle = 1'b0;
    int unsigned cycle_count = 0;
    t_in_item    line_bytes[$];

    command_line_tokenizer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    clt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk)
        out_ready <= no_idle || ($urandom_range(0, 99) >= 10);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic rand_func();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] blank_byte();
        return 8'($urandom_range(1, 32));
    endfunction

    // letters only for the first byte of a word
    function automatic logic [7:0] word_byte(input bit first);
        int k;
        k = first ? $urandom_range(0, 51) : $urandom_range(0, 62);
        if (k < 26)
            return 8'h41 + 8'(k);
        else if (k < 52)
            return 8'h61 + 8'(k - 26);
        else if (k < 62)
            return 8'h30 + 8'(k - 52);
        else
            return CH_UNDER;
    endfunction

    function automatic logic [7:0] bare_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 255));
        while (b == CH_DQUOTE || b == CH_SQUOTE);
        return b;
    endfunction

    task automatic queue_byte(input logic f, input logic [7:0] b);
        t_in_item it;
        it.func     = f;
        it.byte_req = b;
        line_bytes.push_back(it);
    endtask

    // Mostly well-formed lines with random tokens; some noise and corrupted bytes
    task automatic build_random_line();
        int ntok;
        int k;
        logic [7:0] b;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 10))
                queue_byte(rand_func(), 8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 19) == 0)
                queue_byte(rand_func(), blank_byte());
            ntok = $urandom_range(0, 4);
            for (k = 0; k < ntok; k++) begin
                if (k > 0)
                    repeat ($urandom_range(1, 3))
                        queue_byte(rand_func(), blank_byte());
                case ($urandom_range(0, 2))
                    0: begin
                        queue_byte(F_WORD, word_byte(1'b1));
                        repeat ($urandom_range(0, 6))
                            queue_byte(rand_func(), word_byte(1'b0));
                    end
                    1: begin
                        queue_byte(F_PARAM, bare_byte());
                        repeat ($urandom_range(0, 6))
                            queue_byte(rand_func(), bare_byte());
                    end
                    default: begin
                        queue_byte(F_PARAM, CH_DQUOTE);
                        repeat ($urandom_range(0, 6)) begin
                            b = 8'($urandom_range(1, 255));
                            if (b == CH_DQUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
                                queue_byte(rand_func(), CH_BSLASH);
                            queue_byte(rand_func(), b);
                        end
                        if ($urandom_range(0, 11) != 0)
                            queue_byte(rand_func(), CH_DQUOTE);
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3))
                    queue_byte(rand_func(), blank_byte());
            if (line_bytes.size() > 0 && $urandom_range(0, 7) == 0)
                line_bytes[$urandom_range(0, line_bytes.size() - 1)].byte_req =
                    8'($urandom_range(0, 255));
        end
        queue_byte(rand_func(), CH_NUL);
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_item(input t_in_item it);
        no_idle = (sent >= 700) && (sent < 1000);
        while (!no_idle && $urandom_range(0, 99) < 10) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do
            @(posedge i_clk);
        while (!in_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line_bytes();
        while (line_bytes.size() > 0)
            send_item(line_bytes.pop_front());
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty line, then leading whitespace for either token kind
        queue_byte(F_WORD, CH_NUL);
        queue_byte(F_WORD, CH_SPACE);
        queue_byte(F_PARAM, 8'hFF);
        queue_byte(F_WORD, CH_NUL);
        queue_byte(F_PARAM, 8'h01);
        queue_byte(F_WORD, CH_NUL);
        // word, skipped gap, bad word character
        queue_byte(F_WORD, "Z");
        queue_byte(F_PARAM, CH_UNDER);
        queue_byte(F_WORD, CH_SPACE);
        queue_byte(F_PARAM, CH_SPACE);
        queue_byte(F_WORD, "q");
        queue_byte(F_WORD, "-");
        queue_byte(F_PARAM, CH_NUL);
        // single quote inside an unquoted parameter
        queue_byte(F_PARAM, 8'hFF);
        queue_byte(F_PARAM, CH_SQUOTE);
        queue_byte(F_WORD, CH_NUL);
        // escaped quote, closing quote, end of line straight after
        queue_byte(F_PARAM, CH_DQUOTE);
        queue_byte(F_WORD, CH_BSLASH);
        queue_byte(F_WORD, CH_DQUOTE);
        queue_byte(F_PARAM, CH_DQUOTE);
        queue_byte(F_WORD, CH_NUL);
        // empty string followed by a non-space
        queue_byte(F_PARAM, CH_DQUOTE);
        queue_byte(F_PARAM, CH_DQUOTE);
        queue_byte(F_WORD, "y");
        queue_byte(F_WORD, CH_NUL);
        // line ends right after a backslash
        queue_byte(F_PARAM, CH_DQUOTE);
        queue_byte(F_PARAM, CH_BSLASH);
        queue_byte(F_WORD, CH_NUL);
        send_line_bytes();

        while (sent < ITEMS) begin
            build_random_line();
            send_line_bytes();
        end
        in_valid = 1'b0;
        no_idle  = 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
